// ----- hw/rtl/rhgt_pkg.sv -----
// Shared constants, register indexes and helpers of the height grid triangulator.
package rhgt_pkg;

  localparam int unsigned RHGT_MAX_WIDTH   = 4096;
  localparam int unsigned RHGT_MAX_HEIGHT  = 4096;
  localparam int unsigned RHGT_SAMPLE_BITS = 24;

  localparam int unsigned IDX_W      = 24;
  localparam int unsigned COORD_XY_W = 44;
  localparam int unsigned COORD_Z_W  = 55;
  localparam int unsigned DIM_W      = 13;
  localparam int unsigned CFG_W      = 32;
  localparam int unsigned CFG_IDX_W  = 3;

  // Output beat layout, lowest bit first.
  localparam int unsigned OUT_FIELDS_W = IDX_W + 2 * COORD_XY_W + COORD_Z_W + 3 * IDX_W;
  localparam int unsigned OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [DIM_W-1:0] GRID_DIM_RST = DIM_W'(4096);
  localparam logic [CFG_W-1:0] SCALE_RST    = CFG_W'(65536);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_WIDTH  = 3'd0,
    CFG_GRID_HEIGHT = 3'd1,
    CFG_SCALE_X     = 3'd2,
    CFG_SCALE_Y     = 3'd3,
    CFG_SCALE_Z     = 3'd4,
    CFG_DIAG_MODE   = 3'd5
  } cfg_reg_e;

  typedef enum logic {
    REC_VERTEX   = 1'b0,
    REC_TRIANGLE = 1'b1
  } rec_kind_e;

  typedef enum logic {
    DIAG_BC      = 1'b0,
    DIAG_SHORTER = 1'b1
  } diag_mode_e;

  // Clamps a signed value to the range of a signed field of the given width.
  function automatic logic signed [63:0] sat_to(input logic signed [63:0] v,
                                                input int unsigned bits);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = (64'sd1 <<< (bits - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (v > hi) begin
      sat_to = hi;
    end else if (v < lo) begin
      sat_to = lo;
    end else begin
      sat_to = v;
    end
  endfunction

endpackage

// ----- hw/rtl/raster_height_grid_triangulator_unit.sv -----
// Streaming triangulator for a regular elevation grid given in raster order.
//
// Input beats on s_axis carry one height sample and its valid flag. Each
// valid sample produces a vertex record (tuser = 0) with its index and the
// scaled column, row and height. At every pixel that closes a 2x2 quad, up
// to two triangle records (tuser = 1) follow with three vertex indices each.
// tlast marks the final record that a sample causes; a sample that causes
// no record produces no output beat.
// The first record of a sample passes the working stage and then the
// output register. One sample holds the working stage until its last record
// is loaded, so the stage takes a new sample only then; samples that cause
// no record pass at one sample per cycle. The single result register is
// shared by all records of a sample.
// The products of the scale factors are formed as a beat is taken; the
// line of previous-row samples sits in a memory one entry per column.
// A stalled m_axis holds its beat; the working stage then holds a sample that
// still has records to send, and s_axis_tready drops until the stage frees up.
// Reset clears counters, valid flags, corner registers and the configuration
// to its defaults; the line memory is not cleared and needs no clearing pass.
// The user must write configuration through cfg_we_i / cfg_idx_i / cfg_data_i
// only while no sample is in flight; the block itself does not enforce it.
module raster_height_grid_triangulator_unit
  import rhgt_pkg::*;
#(
  parameter int unsigned MAX_WIDTH   = RHGT_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT  = RHGT_MAX_HEIGHT,
  parameter int unsigned SAMPLE_BITS = RHGT_SAMPLE_BITS,
  localparam int unsigned IN_TDATA_W = ((SAMPLE_BITS + 1 + 7) / 8) * 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Configuration write port.
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_W-1:0]       cfg_data_i,
  // Sample stream.
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // tdata: height_sample, sample_valid, zero fill.
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // Record stream.
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // tdata: vertex_index, coord_x, coord_y, coord_z, corner_first,
  // corner_second, corner_third, zero fill.
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // tuser: rec_kind.
  output logic                   m_axis_tuser,
  output logic                   m_axis_tlast
);

  localparam int unsigned CW  = $clog2(MAX_WIDTH);
  localparam int unsigned RW  = $clog2(MAX_HEIGHT);
  localparam int unsigned WW  = (CW + 1 > DIM_W) ? CW + 1 : DIM_W;
  localparam int unsigned HW  = (RW + 1 > DIM_W) ? RW + 1 : DIM_W;
  localparam int unsigned PXW = CFG_W + CW + 1;
  localparam int unsigned PYW = CFG_W + RW + 1;
  localparam int unsigned PZW = CFG_W + SAMPLE_BITS;
  localparam int unsigned EW  = 1 + IDX_W + SAMPLE_BITS;
  localparam int unsigned DW  = SAMPLE_BITS + 1;

  // Configuration registers.
  logic [DIM_W-1:0]        grid_width_q, grid_height_q;
  logic signed [CFG_W-1:0] scale_x_q, scale_y_q, scale_z_q;
  diag_mode_e              diag_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q  <= GRID_DIM_RST;
      grid_height_q <= GRID_DIM_RST;
      scale_x_q     <= SCALE_RST;
      scale_y_q     <= SCALE_RST;
      scale_z_q     <= SCALE_RST;
      diag_mode_q   <= DIAG_BC;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_GRID_WIDTH:  grid_width_q  <= cfg_data_i[DIM_W-1:0];
        CFG_GRID_HEIGHT: grid_height_q <= cfg_data_i[DIM_W-1:0];
        CFG_SCALE_X:     scale_x_q     <= cfg_data_i;
        CFG_SCALE_Y:     scale_y_q     <= cfg_data_i;
        CFG_SCALE_Z:     scale_z_q     <= cfg_data_i;
        CFG_DIAG_MODE:   diag_mode_q   <= diag_mode_e'(cfg_data_i[0]);
        default: ;
      endcase
    end
  end

  // Effective geometry: zero counts as one, large values clamp to the maximum.
  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;

  always_comb begin
    if (grid_width_q == '0) begin
      w_eff = WW'(1);
    end else if (WW'(grid_width_q) > WW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(grid_width_q);
    end
    if (grid_height_q == '0) begin
      h_eff = HW'(1);
    end else if (HW'(grid_height_q) > HW'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(grid_height_q);
    end
  end

  // Input side: position counters and products.
  logic                          s_acc;
  logic signed [SAMPLE_BITS-1:0] h_in;
  logic                          v_in;
  logic [CW-1:0]                 col_q;
  logic [RW-1:0]                 row_q;
  logic                          col_last, row_last;
  logic signed [PXW-1:0]         px;
  logic signed [PYW-1:0]         py;
  logic signed [PZW-1:0]         pz;

  assign s_acc    = s_axis_tvalid && s_axis_tready;
  assign h_in     = s_axis_tdata[SAMPLE_BITS-1:0];
  assign v_in     = s_axis_tdata[SAMPLE_BITS];
  assign col_last = (WW'(col_q) + WW'(1)) >= w_eff;
  assign row_last = (HW'(row_q) + HW'(1)) >= h_eff;
  assign px       = scale_x_q * $signed({1'b0, col_q});
  assign py       = scale_y_q * $signed({1'b0, row_q});
  assign pz       = scale_z_q * h_in;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (s_acc) begin
      if (col_last) begin
        col_q <= '0;
        row_q <= row_last ? '0 : row_q + RW'(1);
      end else begin
        col_q <= col_q + CW'(1);
      end
    end
  end

  // Working stage: one sample with its products and the entry above it.
  logic                          s1_valid_q;
  logic signed [SAMPLE_BITS-1:0] s1_h_q;
  logic                          s1_v_q;
  logic [CW-1:0]                 s1_col_q;
  logic [RW-1:0]                 s1_row_q;
  logic                          s1_fend_q;
  logic signed [PXW-1:0]         s1_px_q;
  logic signed [PYW-1:0]         s1_py_q;
  logic signed [PZW-1:0]         s1_pz_q;
  logic                          commit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_acc) begin
      s1_valid_q <= 1'b1;
    end else if (commit) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      s1_h_q    <= h_in;
      s1_v_q    <= v_in;
      s1_col_q  <= col_q;
      s1_row_q  <= row_q;
      s1_fend_q <= col_last && row_last;
      s1_px_q   <= px;
      s1_py_q   <= py;
      s1_pz_q   <= pz;
    end
  end

  // Line memory, one entry per column: {valid, index, height}.
  logic [EW-1:0] line_mem [MAX_WIDTH];
  logic [EW-1:0] above_q;
  logic [EW-1:0] cur_entry;
  logic [IDX_W-1:0] vcount_q;

  assign cur_entry = {s1_v_q, vcount_q, s1_h_q};

  always_ff @(posedge clk_i) begin
    if (commit) begin
      line_mem[s1_col_q] <= cur_entry;
    end
    if (s_acc) begin
      above_q <= line_mem[col_q];
    end
  end

  logic [EW-1:0] left_q, upper_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q   <= '0;
      upper_q  <= '0;
      vcount_q <= '0;
    end else if (commit) begin
      left_q   <= cur_entry;
      upper_q  <= above_q;
      vcount_q <= s1_fend_q ? '0 : vcount_q + IDX_W'(s1_v_q);
    end
  end

  // Quad corners: a upper left, b upper right, c lower left, d current.
  logic                          a_v, b_v, c_v;
  logic [IDX_W-1:0]              a_i, b_i, c_i;
  logic signed [SAMPLE_BITS-1:0] a_h, b_h, c_h;
  logic signed [DW-1:0]          diff_bc, diff_ad;
  logic [DW-1:0]                 abs_bc, abs_ad;
  logic                          quad, use_bc;
  logic [IDX_W-1:0]              t1_p, t1_q, t1_r, t2_p, t2_q, t2_r;
  logic                          t1_ok, t2_ok;

  assign {a_v, a_i, a_h} = upper_q;
  assign {b_v, b_i, b_h} = above_q;
  assign {c_v, c_i, c_h} = left_q;

  assign diff_bc = DW'(b_h) - DW'(c_h);
  assign diff_ad = DW'(a_h) - DW'(s1_h_q);
  assign abs_bc  = diff_bc[DW-1] ? DW'(-diff_bc) : DW'(diff_bc);
  assign abs_ad  = diff_ad[DW-1] ? DW'(-diff_ad) : DW'(diff_ad);
  assign quad    = (s1_col_q != '0) && (s1_row_q != '0);

  always_comb begin
    if (diag_mode_q == DIAG_BC) begin
      use_bc = 1'b1;
    end else begin
      use_bc = a_v && b_v && c_v && s1_v_q && (abs_bc < abs_ad);
    end
    if (use_bc) begin
      t1_p  = a_i;  t1_q = b_i;      t1_r = c_i;
      t2_p  = c_i;  t2_q = b_i;      t2_r = vcount_q;
      t1_ok = quad && a_v && b_v && c_v;
      t2_ok = quad && c_v && b_v && s1_v_q;
    end else begin
      t1_p  = a_i;  t1_q = b_i;      t1_r = vcount_q;
      t2_p  = a_i;  t2_q = vcount_q; t2_r = c_i;
      t1_ok = quad && a_v && b_v && s1_v_q;
      t2_ok = quad && a_v && s1_v_q && c_v;
    end
  end

  // Records of the sample in order: vertex, first triangle, second triangle.
  logic [2:0] present, sent_q, remain, sel;
  logic       ld_last, out_free, load;

  assign present  = {t2_ok, t1_ok, s1_v_q};
  assign remain   = present & ~sent_q;
  assign sel      = remain & (~remain + 3'd1);
  assign ld_last  = (remain & ~sel) == 3'b000;
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign load     = s1_valid_q && (remain != 3'b000) && out_free;
  assign commit   = s1_valid_q && ((remain == 3'b000) || (load && ld_last));
  assign s_axis_tready = !s1_valid_q || commit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sent_q <= '0;
    end else if (commit) begin
      sent_q <= '0;
    end else if (load) begin
      sent_q <= sent_q | sel;
    end
  end

  // Saturated coordinates of the vertex record.
  logic signed [63:0]       sat_x, sat_y, sat_z;
  logic [OUT_TDATA_W-1:0]   rec_data;
  rec_kind_e                rec_kind;

  assign sat_x = sat_to(64'(s1_px_q), COORD_XY_W);
  assign sat_y = sat_to(64'(s1_py_q), COORD_XY_W);
  assign sat_z = sat_to(64'(s1_pz_q), COORD_Z_W);

  always_comb begin
    if (sel[0]) begin
      rec_kind = REC_VERTEX;
      rec_data = OUT_TDATA_W'({(3 * IDX_W)'(0), sat_z[COORD_Z_W-1:0],
                               sat_y[COORD_XY_W-1:0], sat_x[COORD_XY_W-1:0], vcount_q});
    end else if (sel[1]) begin
      rec_kind = REC_TRIANGLE;
      rec_data = OUT_TDATA_W'({t1_r, t1_q, t1_p,
                               (COORD_Z_W + 2 * COORD_XY_W + IDX_W)'(0)});
    end else begin
      rec_kind = REC_TRIANGLE;
      rec_data = OUT_TDATA_W'({t2_r, t2_q, t2_p,
                               (COORD_Z_W + 2 * COORD_XY_W + IDX_W)'(0)});
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tvalid <= 1'b0;
    end else if (load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      m_axis_tdata <= rec_data;
      m_axis_tuser <= rec_kind;
      m_axis_tlast <= ld_last;
    end
  end

`ifndef SYNTHESIS
  // A triangle record is only issued for a pixel that closes a quad.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && !sel[0]) |-> quad)
    else $error("triangle record issued outside a quad");

  // Records already sent are always among the records the sample causes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> ((sent_q & ~present) == 3'b000))
    else $error("sent record mask out of step with the sample");

  // A valid sample inside a frame advances the vertex index by one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit && s1_v_q && !s1_fend_q) |=> (vcount_q == $past(vcount_q) + IDX_W'(1)))
    else $error("vertex index did not advance");

  // The last sample of a frame restarts vertex numbering.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit && s1_fend_q) |=> (vcount_q == '0))
    else $error("vertex index not cleared at frame end");
`endif

endmodule

// ----- bench/testbench.sv -----
// Self-checking testbench for the raster height grid triangulator unit.
`timescale 1ns / 1ps

module testbench;
  import rhgt_pkg::*;

  localparam int unsigned IN_W = ((RHGT_SAMPLE_BITS + 1 + 7) / 8) * 8;
  localparam int unsigned OFF_X = IDX_W;
  localparam int unsigned OFF_Y = OFF_X + COORD_XY_W;
  localparam int unsigned OFF_Z = OFF_Y + COORD_XY_W;
  localparam int unsigned OFF_C0 = OFF_Z + COORD_Z_W;
  localparam int unsigned OFF_C1 = OFF_C0 + IDX_W;
  localparam int unsigned OFF_C2 = OFF_C1 + IDX_W;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct packed {
    logic ok;
    logic [IDX_W-1:0] idx;
    logic signed [RHGT_SAMPLE_BITS-1:0] h;
  } grid_cell_t;

  typedef struct packed {
    rec_kind_e kind;
    logic [IDX_W-1:0] vidx;
    logic [COORD_XY_W-1:0] x;
    logic [COORD_XY_W-1:0] y;
    logic [COORD_Z_W-1:0] z;
    logic [IDX_W-1:0] c0;
    logic [IDX_W-1:0] c1;
    logic [IDX_W-1:0] c2;
    logic is_last;
  } record_t;

  logic clk_i;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic s_valid = 1'b0;
  logic [IN_W-1:0] s_data = '0;
  logic m_ready = 1'b0;
  logic s_axis_tready;
  logic m_axis_tvalid;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic m_axis_tuser;
  logic m_axis_tlast;

  raster_height_grid_triangulator_unit DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .s_axis_tvalid(s_valid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_data),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_ready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  // Mirror of the block's configuration and grid state.
  logic [DIM_W-1:0] width_cfg;
  logic [DIM_W-1:0] height_cfg;
  logic signed [CFG_W-1:0] sx;
  logic signed [CFG_W-1:0] sy;
  logic signed [CFG_W-1:0] sz;
  diag_mode_e diag_sel;
  grid_cell_t line_mem [RHGT_MAX_WIDTH];
  grid_cell_t left_cell;
  grid_cell_t upleft_cell;
  int unsigned col_q;
  int unsigned row_q;
  logic [IDX_W-1:0] next_index;

  record_t pending_records[$];
  int unsigned mismatches = 0;
  int unsigned burst_left = 0;
  bit sender_gaps = 1'b1;
  int unsigned hold_request = 0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic int unsigned eff_dim(input logic [DIM_W-1:0] v, input int unsigned limit);
    if (v == 0) return 1;
    if (v > limit) return limit;
    return v;
  endfunction

  function automatic longint clamp_field(input longint v, input int unsigned bits);
    longint lim;
    lim = longint'(64'd1 << (bits - 1));
    if (v >= lim) return lim - 1;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic longint height_gap(input longint p, input longint q);
    return (p > q) ? p - q : q - p;
  endfunction

  function automatic string record_text(input record_t r);
    return $sformatf("kind=%0d index=%0d x=%h y=%h z=%h corners=%0d/%0d/%0d last=%0d",
                     r.kind, r.vidx, r.x, r.y, r.z, r.c0, r.c1, r.c2, r.is_last);
  endfunction

  // Works out the records one accepted sample causes and queues them.
  task automatic predict_sample(input logic signed [RHGT_SAMPLE_BITS-1:0] h, input bit ok);
    int unsigned w;
    int unsigned ht;
    int n;
    bit bc_split;
    grid_cell_t cur;
    grid_cell_t a;
    grid_cell_t b;
    grid_cell_t c;
    grid_cell_t corner [2][3];
    record_t recs [3];
    record_t r;
    w = eff_dim(width_cfg, RHGT_MAX_WIDTH);
    ht = eff_dim(height_cfg, RHGT_MAX_HEIGHT);
    n = 0;
    cur.ok = ok;
    cur.h = h;
    cur.idx = '0;
    if (ok) begin
      cur.idx = next_index;
      next_index = next_index + 1'b1;
      r = '0;
      r.kind = REC_VERTEX;
      r.vidx = cur.idx;
      r.x = COORD_XY_W'(clamp_field(longint'(sx) * longint'(col_q), COORD_XY_W));
      r.y = COORD_XY_W'(clamp_field(longint'(sy) * longint'(row_q), COORD_XY_W));
      r.z = COORD_Z_W'(clamp_field(longint'(sz) * longint'(h), COORD_Z_W));
      recs[n] = r;
      n++;
    end
    a = upleft_cell;
    b = line_mem[col_q];
    c = left_cell;
    if (col_q > 0 && row_q > 0) begin
      if (diag_sel == DIAG_BC) begin
        bc_split = 1'b1;
      end else if (a.ok && b.ok && c.ok && cur.ok) begin
        bc_split = height_gap(b.h, c.h) < height_gap(a.h, cur.h);
      end else begin
        bc_split = 1'b0;
      end
      if (bc_split) begin
        corner = '{'{a, b, c}, '{c, b, cur}};
      end else begin
        corner = '{'{a, b, cur}, '{a, cur, c}};
      end
      for (int t = 0; t < 2; t++) begin
        if (corner[t][0].ok && corner[t][1].ok && corner[t][2].ok) begin
          r = '0;
          r.kind = REC_TRIANGLE;
          r.c0 = corner[t][0].idx;
          r.c1 = corner[t][1].idx;
          r.c2 = corner[t][2].idx;
          recs[n] = r;
          n++;
        end
      end
    end
    upleft_cell = b;
    line_mem[col_q] = cur;
    left_cell = cur;
    if (col_q + 1 >= w) begin
      col_q = 0;
      if (row_q + 1 >= ht) begin
        row_q = 0;
        next_index = '0;
      end else begin
        row_q++;
      end
    end else begin
      col_q++;
    end
    if (n > 0) recs[n-1].is_last = 1'b1;
    for (int k = 0; k < n; k++) pending_records.push_back(recs[k]);
  endtask

  // Offers one sample in the current burst and returns once it is taken.
  task automatic send_sample(input logic signed [RHGT_SAMPLE_BITS-1:0] h, input bit ok);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (sender_gaps && $urandom_range(0, 3) != 0) ? $urandom_range(1, 6) : 0;
      if (gap != 0) begin
        s_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_valid <= 1'b1;
    s_data <= {{(IN_W - RHGT_SAMPLE_BITS - 1){1'b0}}, ok, h};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_sample(h, ok);
  endtask

  task automatic write_reg(input cfg_reg_e reg_sel, input logic [CFG_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_idx <= reg_sel;
    cfg_data <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
    case (reg_sel)
      CFG_GRID_WIDTH: width_cfg = value[DIM_W-1:0];
      CFG_GRID_HEIGHT: height_cfg = value[DIM_W-1:0];
      CFG_SCALE_X: sx = value;
      CFG_SCALE_Y: sy = value;
      CFG_SCALE_Z: sz = value;
      CFG_DIAG_MODE: diag_sel = diag_mode_e'(value[0]);
      default: ;
    endcase
  endtask

  // Invalid samples never produce a record, so allow the pipe to empty afterwards.
  task automatic wait_idle();
    s_valid <= 1'b0;
    while (pending_records.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  function automatic logic signed [RHGT_SAMPLE_BITS-1:0] random_height();
    int v;
    if ($urandom_range(0, 1) != 0) return RHGT_SAMPLE_BITS'($urandom);
    v = int'($urandom_range(0, 15)) - 8;
    return v[RHGT_SAMPLE_BITS-1:0];
  endfunction

  function automatic logic [CFG_W-1:0] pick_scale();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return '0;
      3: return CFG_W'($urandom_range(0, 262143)) - 32'h0002_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [DIM_W-1:0] pick_dim();
    case ($urandom_range(0, 19))
      0: return '0;
      1: return 13'h1fff;
      2: return DIM_W'(4096);
      default: return DIM_W'($urandom_range(1, 6));
    endcase
  endfunction

  task automatic align_frame();
    while (col_q != 0 || row_q != 0) send_sample(random_height(), 1'b0);
  endtask

  // Growing the row mid-frame would read line entries never written, so a
  // wider row only starts on the first row of a frame.
  task automatic set_geometry(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
    write_reg(CFG_GRID_HEIGHT, CFG_W'(h));
    if (eff_dim(w, RHGT_MAX_WIDTH) > eff_dim(width_cfg, RHGT_MAX_WIDTH) && row_q != 0) begin
      align_frame();
      wait_idle();
    end
    write_reg(CFG_GRID_WIDTH, CFG_W'(w));
  endtask

  task automatic test_default_config();
    send_sample(24'sh800000, 1'b1);
    send_sample(24'sh7fffff, 1'b1);
    send_sample(24'shffffff, 1'b0);
    send_sample(24'sh000000, 1'b1);
  endtask

  task automatic test_fixed_split();
    wait_idle();
    write_reg(CFG_SCALE_X, 32'h0001_8000);
    write_reg(CFG_SCALE_Y, 32'hffff_0000);
    write_reg(CFG_SCALE_Z, 32'h8000_0000);
    write_reg(CFG_DIAG_MODE, CFG_W'(DIAG_BC));
    set_geometry(DIM_W'(3), DIM_W'(2));
    align_frame();
    // The second quad loses its lower right corner and keeps one triangle.
    send_sample(24'sh800000, 1'b1);
    send_sample(24'sh000005, 1'b1);
    send_sample(24'sh000007, 1'b1);
    send_sample(24'sh000003, 1'b1);
    send_sample(24'sh7fffff, 1'b1);
    send_sample(24'sh000009, 1'b0);
  endtask

  task automatic test_shorter_diagonal();
    wait_idle();
    write_reg(CFG_DIAG_MODE, CFG_W'(DIAG_SHORTER));
    write_reg(CFG_SCALE_Z, 32'h7fff_ffff);
    set_geometry(DIM_W'(2), DIM_W'(2));
    // b-c difference clearly shorter.
    send_sample(24'sh800000, 1'b1);
    send_sample(24'sh00000a, 1'b1);
    send_sample(24'sh00000c, 1'b1);
    send_sample(24'sh7fffff, 1'b1);
    // Both differences equal: the a-d split wins the tie.
    send_sample(24'sh000000, 1'b1);
    send_sample(24'sh000000, 1'b1);
    send_sample(24'sh000032, 1'b1);
    send_sample(24'sh000032, 1'b1);
    // Missing lower left corner forces the a-d split.
    send_sample(24'sh000001, 1'b1);
    send_sample(24'sh000002, 1'b1);
    send_sample(24'sh000002, 1'b0);
    send_sample(24'sh000001, 1'b1);
  endtask

  task automatic test_degenerate_geometry();
    wait_idle();
    set_geometry('0, '0);
    send_sample(24'sh123456, 1'b1);
    send_sample(24'sh654321, 1'b0);
    send_sample(24'shfedcba, 1'b1);
  endtask

  // An oversized width clamps to the line length and a zero height keeps
  // every sample on the first row.
  task automatic test_wide_row();
    wait_idle();
    write_reg(CFG_SCALE_X, 32'h7fff_ffff);
    write_reg(CFG_SCALE_Y, 32'h8000_0000);
    set_geometry(13'h1fff, '0);
    repeat (9) send_sample(random_height(), $urandom_range(0, 1) != 0);
    send_sample(24'sh000100, 1'b1);
    send_sample(24'sh800000, 1'b1);
    send_sample(24'sh7fffff, 1'b1);
  endtask

  task automatic test_output_hold_off();
    wait_idle();
    write_reg(CFG_SCALE_X, pick_scale());
    write_reg(CFG_SCALE_Y, pick_scale());
    write_reg(CFG_SCALE_Z, pick_scale());
    set_geometry(DIM_W'(4), DIM_W'(3));
    sender_gaps = 1'b0;
    hold_request = 250;
    repeat (30) send_sample(random_height(), 1'b1);
    sender_gaps = 1'b1;
  endtask

  task automatic test_drain_pause();
    repeat (12) send_sample(random_height(), $urandom_range(0, 9) != 0);
    wait_idle();
    repeat (12) send_sample(random_height(), $urandom_range(0, 9) != 0);
  endtask

  task automatic test_random_phases();
    for (int p = 0; p < 8; p++) begin
      wait_idle();
      write_reg(CFG_SCALE_X, pick_scale());
      write_reg(CFG_SCALE_Y, pick_scale());
      write_reg(CFG_SCALE_Z, pick_scale());
      write_reg(CFG_DIAG_MODE, CFG_W'(($urandom_range(0, 1) != 0) ? DIAG_SHORTER : DIAG_BC));
      set_geometry(pick_dim(), pick_dim());
      repeat (30) send_sample(random_height(), $urandom_range(0, 99) < 85);
    end
  endtask

  task automatic note_failure(input string msg);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) $display("%0t: %s", $realtime, msg);
  endtask

  always @(posedge clk_i) begin : check_records
    record_t got;
    record_t want;
    string bad;
    if (rst_n && m_axis_tvalid && m_ready) begin
      got.kind = rec_kind_e'(m_axis_tuser);
      got.vidx = m_axis_tdata[0 +: IDX_W];
      got.x = m_axis_tdata[OFF_X +: COORD_XY_W];
      got.y = m_axis_tdata[OFF_Y +: COORD_XY_W];
      got.z = m_axis_tdata[OFF_Z +: COORD_Z_W];
      got.c0 = m_axis_tdata[OFF_C0 +: IDX_W];
      got.c1 = m_axis_tdata[OFF_C1 +: IDX_W];
      got.c2 = m_axis_tdata[OFF_C2 +: IDX_W];
      got.is_last = m_axis_tlast;
      if (pending_records.size() == 0) begin
        note_failure({"record with none expected: ", record_text(got)});
      end else begin
        want = pending_records.pop_front();
        bad = "";
        if (got.kind !== want.kind) bad = {bad, " kind"};
        if (got.vidx !== want.vidx) bad = {bad, " vertex_index"};
        if (got.x !== want.x) bad = {bad, " coord_x"};
        if (got.y !== want.y) bad = {bad, " coord_y"};
        if (got.z !== want.z) bad = {bad, " coord_z"};
        if (got.c0 !== want.c0) bad = {bad, " corner_first"};
        if (got.c1 !== want.c1) bad = {bad, " corner_second"};
        if (got.c2 !== want.c2) bad = {bad, " corner_third"};
        if (got.is_last !== want.is_last) bad = {bad, " last"};
        if (bad != "") begin
          note_failure($sformatf("wrong%s\n  expected %s\n  actual   %s",
                                 bad, record_text(want), record_text(got)));
        end
      end
    end
  end

  // Output side: switches among three stall styles at random, and holds
  // off when a test asks for it.
  initial begin : output_stalls
    int unsigned style;
    int unsigned left;
    int unsigned tick;
    int unsigned hold_left;
    style = 0;
    left = 0;
    tick = 0;
    forever begin
      @(posedge clk_i);
      if (hold_request != 0) begin
        hold_left = hold_request;
        hold_request = 0;
        m_ready <= 1'b0;
        while (hold_left != 0) begin
          @(posedge clk_i);
          hold_left--;
        end
      end
      if (left == 0) begin
        style = $urandom_range(0, 2);
        left = $urandom_range(20, 80);
      end
      left--;
      tick++;
      case (style)
        0: m_ready <= 1'b1;
        1: m_ready <= (tick % 4) != 1;
        default: m_ready <= $urandom_range(0, 1) != 0;
      endcase
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((s_valid && s_axis_tready) || (m_axis_tvalid && m_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("testbench failed");
    $finish;
  end

  initial begin : run
    width_cfg = GRID_DIM_RST;
    height_cfg = GRID_DIM_RST;
    sx = SCALE_RST;
    sy = SCALE_RST;
    sz = SCALE_RST;
    diag_sel = DIAG_BC;
    foreach (line_mem[i]) line_mem[i] = '0;
    left_cell = '0;
    upleft_cell = '0;
    col_q = 0;
    row_q = 0;
    next_index = '0;
    repeat (10) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);
    test_default_config();
    test_fixed_split();
    test_shorter_diagonal();
    test_degenerate_geometry();
    test_wide_row();
    test_output_hold_off();
    test_drain_pause();
    test_random_phases();
    wait_idle();
    if (mismatches == 0 && pending_records.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/rhgt_pkg.sv
hw/rtl/raster_height_grid_triangulator_unit.sv
bench/testbench.sv
